FILE: src/mhpq_pkg.sv
// Package for the max-heap priority queue: entry, status and command types.
// Shared by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mhpq_pkg;

    localparam int CODE_W  = 32;
    localparam int PRIO_W  = 32;
    localparam int LIMIT_W = 7;
    localparam int ENTRY_W = CODE_W + PRIO_W;

    localparam logic [LIMIT_W-1:0] CAP_RESET = 7'd64;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    typedef struct packed {
        logic        [CODE_W-1:0] code;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_EXTRACTED = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_LEFT,
        RD_RIGHT
    } t_rd_sel;

    typedef struct packed {
        logic    load_item;
        logic    cap_root;
        logic    ext_setup;
        logic    cap_left;
        logic    up_step;
        logic    dn_step;
        logic    wr_item;
        logic    res_ld;
        t_status res_st;
        t_rd_sel rd;
    } t_ctl;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic l_ok;
        logic r_ok;
        logic dn_swap;
    } t_stat;

endpackage

`default_nettype wire

FILE: src/mhpq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/mhpq_ctrl.sv
// Controller of the max-heap priority queue: sequences inserts and extracts.
// Depends on mhpq_pkg; drives the datapath through t_ctl and reads t_stat.
`default_nettype none

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire logic  i_cmd,
    input  wire t_stat i_stat,
    output t_ctl       o_ctl,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EX_LAST,
        S_EX_SET,
        S_UP,
        S_UP_CMP,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_INSERT) begin
                        if (i_stat.full) begin
                            o_ctl.res_ld = 1'b1;
                            o_ctl.res_st = ST_DROPPED;
                            n_valid      = 1'b1;
                        end else begin
                            o_ctl.load_item = 1'b1;
                            n_state         = S_UP;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_ctl.res_ld = 1'b1;
                            o_ctl.res_st = ST_EMPTY;
                            n_valid      = 1'b1;
                        end else begin
                            o_ctl.rd = RD_ROOT;
                            n_state  = S_EX_LAST;
                        end
                    end
                end
            end
            S_EX_LAST: begin
                o_ctl.cap_root = 1'b1;
                o_ctl.rd       = RD_LAST;
                n_state        = S_EX_SET;
            end
            S_EX_SET: begin
                o_ctl.ext_setup = 1'b1;
                n_state         = S_DN_L;
            end
            S_UP: begin
                if (i_stat.at_root) begin
                    o_ctl.wr_item = 1'b1;
                    o_ctl.res_ld  = 1'b1;
                    o_ctl.res_st  = ST_INSERTED;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_ctl.rd = RD_PARENT;
                    n_state  = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.up_swap) begin
                    o_ctl.up_step = 1'b1;
                    n_state       = S_UP;
                end else begin
                    o_ctl.wr_item = 1'b1;
                    o_ctl.res_ld  = 1'b1;
                    o_ctl.res_st  = ST_INSERTED;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DN_L: begin
                if (!i_stat.l_ok) begin
                    o_ctl.wr_item = 1'b1;
                    o_ctl.res_ld  = 1'b1;
                    o_ctl.res_st  = ST_EXTRACTED;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_ctl.rd = RD_LEFT;
                    n_state  = S_DN_R;
                end
            end
            S_DN_R: begin
                o_ctl.cap_left = 1'b1;
                if (i_stat.r_ok) begin
                    o_ctl.rd = RD_RIGHT;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.dn_swap) begin
                    o_ctl.dn_step = 1'b1;
                    n_state       = S_DN_L;
                end else begin
                    o_ctl.wr_item = 1'b1;
                    o_ctl.res_ld  = 1'b1;
                    o_ctl.res_st  = ST_EXTRACTED;
                    n_valid       = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // A result is only ever presented once the sequencer has returned to idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe raised while an operation is in progress");

endmodule

`default_nettype wire

FILE: src/mhpq_dp.sv
// Datapath of the max-heap priority queue: entry store, count, sift registers.
// Depends on mhpq_pkg and mhpq_ram; driven by mhpq_ctrl through t_ctl.
`default_nettype none

module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic        [LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic signed [CODE_W-1:0]  i_item_code,
    input  wire logic signed [PRIO_W-1:0]  i_item_priority,
    input  wire t_ctl                      i_ctl,
    output t_stat                          o_stat,
    output logic             [1:0]         o_status,
    output logic signed      [CODE_W-1:0]  o_out_code,
    output logic signed      [PRIO_W-1:0]  o_out_priority
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int XW = AW + 2;

    logic [CW-1:0]      r_count;
    logic [LIMIT_W-1:0] r_limit;
    logic [AW-1:0]      r_pos;
    t_entry             r_item;
    t_entry             r_left;
    t_entry             r_root;
    t_status            r_status;
    logic [CODE_W-1:0]  r_code;
    logic [PRIO_W-1:0]  r_prio;

    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_ent;
    logic               ram_we;
    t_entry             ram_wdata;
    logic [AW-1:0]      ram_raddr;

    logic [LW-1:0]      lim_ext;
    logic [LW-1:0]      lim_eff;
    logic [AW-1:0]      pos_m1;
    logic [AW-1:0]      par_idx;
    logic [AW-1:0]      last_idx;
    logic [XW-1:0]      l_wide;
    logic [XW-1:0]      r_wide;
    logic [XW-1:0]      cnt_wide;
    logic               lbig;
    logic               rbig;
    logic [PRIO_W-1:0]  best_prio;
    t_entry             dn_child;
    logic [AW-1:0]      dn_idx;

    assign rd_ent    = ram_rdata;
    assign lim_ext   = LW'(r_limit);
    assign lim_eff   = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
    assign pos_m1    = r_pos - AW'(1);
    assign par_idx   = pos_m1 >> 1;
    assign last_idx  = AW'(r_count - CW'(1));
    assign l_wide    = {1'b0, r_pos, 1'b1};
    assign r_wide    = l_wide + XW'(1);
    assign cnt_wide  = XW'(r_count);

    assign lbig      = $signed(r_left.prio) > $signed(r_item.prio);
    assign best_prio = lbig ? r_left.prio : r_item.prio;
    assign rbig      = o_stat.r_ok && ($signed(rd_ent.prio) > $signed(best_prio));
    assign dn_child  = rbig ? rd_ent : r_left;
    assign dn_idx    = rbig ? r_wide[AW-1:0] : l_wide[AW-1:0];

    always_comb begin
        o_stat.full    = (LW'(r_count) >= lim_eff);
        o_stat.empty   = (r_count == '0);
        o_stat.at_root = (r_pos == '0);
        o_stat.up_swap = $signed(r_item.prio) > $signed(rd_ent.prio);
        o_stat.l_ok    = (l_wide < cnt_wide);
        o_stat.r_ok    = (r_wide < cnt_wide);
        o_stat.dn_swap = lbig || rbig;
    end

    always_comb begin
        case (i_ctl.rd)
            RD_PARENT: ram_raddr = par_idx;
            RD_ROOT:   ram_raddr = '0;
            RD_LAST:   ram_raddr = last_idx;
            RD_LEFT:   ram_raddr = l_wide[AW-1:0];
            RD_RIGHT:  ram_raddr = r_wide[AW-1:0];
            default:   ram_raddr = '0;
        endcase
    end

    assign ram_we    = i_ctl.wr_item || i_ctl.up_step || i_ctl.dn_step;
    assign ram_wdata = i_ctl.wr_item ? r_item : (i_ctl.up_step ? rd_ent : dn_child);

    mhpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.rd != RD_NONE),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_ctl.load_item) begin
                r_count <= r_count + CW'(1);
            end else if (i_ctl.ext_setup) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_item.code <= i_item_code;
            r_item.prio <= i_item_priority;
            r_pos       <= r_count[AW-1:0];
        end
        if (i_ctl.ext_setup) begin
            r_item <= rd_ent;
            r_pos  <= '0;
        end
        if (i_ctl.up_step) begin
            r_pos <= par_idx;
        end
        if (i_ctl.dn_step) begin
            r_pos <= dn_idx;
        end
        if (i_ctl.cap_root) begin
            r_root <= rd_ent;
        end
        if (i_ctl.cap_left) begin
            r_left <= rd_ent;
        end
        if (i_ctl.res_ld) begin
            r_status <= i_ctl.res_st;
            r_code   <= (i_ctl.res_st == ST_EXTRACTED) ? r_root.code : '0;
            r_prio   <= (i_ctl.res_st == ST_EXTRACTED) ? r_root.prio : '0;
        end
    end

    assign o_status       = r_status;
    assign o_out_code     = r_code;
    assign o_out_priority = r_prio;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds the store depth");

    // Child reads must stay inside the live part of the heap.
    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.rd == RD_LEFT) |-> o_stat.l_ok)
        else $error("left child read beyond the last entry");

    a_right_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.rd == RD_RIGHT) |-> o_stat.r_ok)
        else $error("right child read beyond the last entry");

    a_last_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.rd == RD_LAST) |-> !o_stat.empty)
        else $error("last entry read from an empty heap");

endmodule

`default_nettype wire

FILE: src/max_heap_priority_queue.sv
// Binary max-heap priority queue of code and priority pairs. An insert lets
// the new entry climb toward the root, and an extract lets the last entry,
// moved to the root, sink; either way the entry moves one level at a time,
// at most log2(DEPTH) levels. A dropped insert or an extract from an empty
// heap is reported on the cycle after acceptance. The single read port of the
// entry RAM gives one read per cycle: one parent per level going up, two
// children per level going down. Results cannot be stalled; each is shown on
// o_valid for one cycle, and busy falls in that same cycle so the next command
// may be transferred at once.
// Depends on mhpq_pkg, mhpq_ctrl, mhpq_dp and mhpq_ram.
`default_nettype none

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic        [LIMIT_W-1:0] i_cfg_wdata,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_cmd,
    input  wire logic signed [CODE_W-1:0]  i_item_code,
    input  wire logic signed [PRIO_W-1:0]  i_item_priority,
    output logic                           o_valid,
    output logic             [1:0]         o_status,
    output logic signed      [CODE_W-1:0]  o_out_code,
    output logic signed      [PRIO_W-1:0]  o_out_priority
);

    t_ctl  ctl;
    t_stat stat;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    mhpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_code     (i_item_code),
        .i_item_priority (i_item_priority),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .o_status        (o_status),
        .o_out_code      (o_out_code),
        .o_out_priority  (o_out_priority)
    );

endmodule

`default_nettype wire
